FILE: rtl/bavm_pkg.sv
// ----------------------------------------------------------------------------
// bavm_pkg
// shared types and constants of the byte accumulator machine core
// ----------------------------------------------------------------------------
package bavm_pkg;

  localparam int MemDepth = 256;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int DataW    = 8;
  localparam int PtrW     = 16;
  localparam int StepW    = 17;
  localparam int FuncW    = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 17;

  localparam logic [PtrW-1:0]  ProgLenReset  = 16'd256;
  localparam logic [StepW-1:0] MaxStepsReset = 17'd100000;

  localparam logic [CfgIdxW-1:0] CfgProgLen  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSteps = 1'd1;

  typedef enum logic [FuncW-1:0] {
    FnLdAcc    = 5'd0,
    FnLdAddr   = 5'd1,
    FnNop      = 5'd2,
    FnJz       = 5'd3,
    FnJmp      = 5'd4,
    FnStore    = 5'd5,
    FnLoad     = 5'd6,
    FnSwapAddr = 5'd7,
    FnSwap2    = 5'd8,
    FnSwap3    = 5'd9,
    FnSwap4    = 5'd10,
    FnTerm     = 5'd11,
    FnInc      = 5'd12,
    FnAdd      = 5'd13,
    FnSub      = 5'd14,
    FnDiv      = 5'd15,
    FnMul      = 5'd16,
    FnRestart  = 5'd17,
    FnPreload  = 5'd18
  } func_e;

  typedef enum logic [1:0] {
    AluAdd = 2'd0,
    AluSub = 2'd1,
    AluMul = 2'd2,
    AluDiv = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic             clear;
    logic             we;
    logic [MemAw-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [MemAw-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/bavm_mem.sv
// ----------------------------------------------------------------------------
// bavm_mem
// data memory with per-entry valid bits, registered read, clear of all entries at once
// ----------------------------------------------------------------------------
module bavm_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bavm_pkg::mem_req_t         req_i,
  output logic [bavm_pkg::DataW-1:0] rdata_o
);
  import bavm_pkg::*;

  logic [DataW-1:0]    mem_q [MemDepth];
  logic [MemDepth-1:0] valid_q;
  logic [DataW-1:0]    rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.clear) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= valid_q[req_i.raddr];
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  // unwritten entries read as zero
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: rtl/bavm_alu.sv
// ----------------------------------------------------------------------------
// bavm_alu
// shared adder: one-step add and sub, eight-step shift-add multiply and
// restoring divide
// ----------------------------------------------------------------------------
module bavm_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bavm_pkg::alu_req_t req_i,
  output bavm_pkg::alu_rsp_t rsp_o
);
  import bavm_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  alu_op_e         op_q, op_d;
  logic [DataW-1:0] r_q, r_d;
  logic [DataW-1:0] s_q, s_d;
  logic [DataW-1:0] t_q, t_d;

  logic [DataW:0]   x_w;
  logic [DataW:0]   y_w;
  logic             sub_w;
  logic [DataW+1:0] sum_w;

  always_comb begin
    if (busy_q) begin
      if (op_q == AluDiv) begin
        x_w   = {r_q, s_q[DataW-1]};
        y_w   = {1'b0, t_q};
        sub_w = 1'b1;
      end else begin
        x_w   = {1'b0, r_q};
        y_w   = {1'b0, s_q};
        sub_w = 1'b0;
      end
    end else begin
      x_w   = {1'b0, req_i.a};
      y_w   = {1'b0, req_i.b};
      sub_w = (req_i.op == AluSub);
    end
    sum_w = {1'b0, x_w} + {1'b0, (sub_w ? ~y_w : y_w)} + {{(DataW+1){1'b0}}, sub_w};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    r_d    = r_q;
    s_d    = s_q;
    t_d    = t_q;
    if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (op_q == AluDiv) begin
        if (sum_w[DataW+1]) begin
          r_d = sum_w[DataW-1:0];
          s_d = {s_q[DataW-2:0], 1'b1};
        end else begin
          r_d = {r_q[DataW-2:0], s_q[DataW-1]};
          s_d = {s_q[DataW-2:0], 1'b0};
        end
      end else begin
        if (t_q[0]) begin
          r_d = sum_w[DataW-1:0];
        end
        s_d = {s_q[DataW-2:0], 1'b0};
        t_d = {1'b0, t_q[DataW-1:1]};
      end
      if (cnt_q == CntW'(DataW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      op_d  = req_i.op;
      cnt_d = '0;
      case (req_i.op)
        AluMul: begin
          busy_d = 1'b1;
          r_d    = '0;
          s_d    = req_i.b;
          t_d    = req_i.a;
        end
        AluDiv: begin
          busy_d = 1'b1;
          r_d    = '0;
          s_d    = req_i.a;
          t_d    = req_i.b;
        end
        default: begin
          r_d    = sum_w[DataW-1:0];
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= AluAdd;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    s_q <= s_d;
    t_q <= t_d;
  end

  // divide by zero gives zero
  always_comb begin
    rsp_o.done = done_q;
    if (op_q == AluDiv) begin
      rsp_o.result = (t_q == '0) ? '0 : s_q;
    end else begin
      rsp_o.result = r_q;
    end
  end

endmodule

FILE: rtl/byte_accumulator_vm_core.sv
// ----------------------------------------------------------------------------
// byte_accumulator_vm_core
// execute core of a small 8-bit accumulator machine
// ----------------------------------------------------------------------------
// One input beat carries one func code (instruction, restart or preload)
// and gives one output beat: accumulator, next instruction pointer and the
// halted flag after that item. Both channels use valid and stall.
// The core takes one item at a time; in_stall_o is high while it works.
// Increment, add and sub go through the arithmetic unit; mul and div
// run eight steps of the shared adder in that unit. The output beat
// sits in its own register, so a new item is taken while the previous
// result waits; an item only finishes once that register is free, so a
// stalled receiver holds the core after at most one further item.
// Reset (and the restart code) clears all machine registers, the pointer,
// the step count and the done flag; the data memory is cleared at once
// through per-entry valid bits. Config registers are written through the
// cfg port; the user must write them only while idle, as the core does
// not enforce it. They keep their values over a restart.
// ----------------------------------------------------------------------------
module byte_accumulator_vm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bavm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bavm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bavm_pkg::FuncW-1:0]    func_i,
  input  logic [bavm_pkg::DataW-1:0]    literal_i,
  input  logic [bavm_pkg::MemAw-1:0]    preload_address_i,
  input  logic [bavm_pkg::DataW-1:0]    preload_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bavm_pkg::DataW-1:0]    accumulator_o,
  output logic [bavm_pkg::PtrW-1:0]     next_pointer_o,
  output logic                          halted_o
);
  import bavm_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StExec = 4'b0010,
    StAlu  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [PtrW-1:0]  prog_len_q;
  logic [StepW-1:0] max_steps_q;

  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] addr_q, addr_d;
  logic [DataW-1:0] spare_q [3];
  logic [DataW-1:0] spare_d [3];
  logic [PtrW-1:0]  ip_q, ip_d;
  logic [StepW-1:0] step_q, step_d;
  logic             term_q, term_d;

  logic [FuncW-1:0] func_q;
  logic [DataW-1:0] lit_q;
  logic [MemAw-1:0] paddr_q;
  logic [DataW-1:0] pval_q;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_acc_q;
  logic [PtrW-1:0]  out_ptr_q;
  logic             out_halt_q;
  logic             out_load;

  logic             in_accept;
  logic             halted_w;
  logic [DataW-1:0] mem_rdata;
  mem_req_t         mem_req;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  assign in_accept = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign halted_w  = term_q || (ip_q >= prog_len_q) || (step_q >= max_steps_q);
  assign out_load  = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  bavm_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bavm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    addr_d     = addr_q;
    spare_d    = spare_q;
    ip_d       = ip_q;
    step_d     = step_q;
    term_d     = term_q;
    mem_req    = '{clear: 1'b0, we: 1'b0, waddr: paddr_q, wdata: pval_q, raddr: addr_q};
    alu_req    = '{start: 1'b0, op: AluAdd, a: acc_q, b: mem_rdata};

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StOut;
        if (func_q == FnRestart) begin
          acc_d         = '0;
          addr_d        = '0;
          spare_d       = '{default: '0};
          ip_d          = '0;
          step_d        = '0;
          term_d        = 1'b0;
          mem_req.clear = 1'b1;
        end else if (func_q == FnPreload) begin
          mem_req.we = 1'b1;
        end else if (!halted_w) begin
          ip_d   = ip_q + 1'b1;
          step_d = step_q + 1'b1;
          case (func_e'(func_q))
            FnLdAcc:  acc_d = lit_q;
            FnLdAddr: addr_d = lit_q;
            FnJz: begin
              if (acc_q == '0) begin
                ip_d = {{(PtrW-DataW){1'b0}}, addr_q};
              end
            end
            FnJmp:    ip_d = {{(PtrW-DataW){1'b0}}, addr_q};
            FnStore: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = addr_q;
              mem_req.wdata = acc_q;
            end
            FnLoad:   acc_d = mem_rdata;
            FnSwapAddr: begin
              acc_d  = addr_q;
              addr_d = acc_q;
            end
            FnSwap2: begin
              acc_d      = spare_q[0];
              spare_d[0] = acc_q;
            end
            FnSwap3: begin
              acc_d      = spare_q[1];
              spare_d[1] = acc_q;
            end
            FnSwap4: begin
              acc_d      = spare_q[2];
              spare_d[2] = acc_q;
            end
            FnTerm:   term_d = 1'b1;
            FnInc: begin
              alu_req.start = 1'b1;
              alu_req.b     = DataW'(1);
              state_d       = StAlu;
            end
            FnAdd: begin
              alu_req.start = 1'b1;
              state_d       = StAlu;
            end
            FnSub: begin
              alu_req.start = 1'b1;
              alu_req.op    = AluSub;
              state_d       = StAlu;
            end
            FnDiv: begin
              alu_req.start = 1'b1;
              alu_req.op    = AluDiv;
              state_d       = StAlu;
            end
            FnMul: begin
              alu_req.start = 1'b1;
              alu_req.op    = AluMul;
              state_d       = StAlu;
            end
            default: ;
          endcase
        end
      end
      StAlu: begin
        if (alu_rsp.done) begin
          acc_d   = alu_rsp.result;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prog_len_q  <= ProgLenReset;
      max_steps_q <= MaxStepsReset;
      acc_q       <= '0;
      addr_q      <= '0;
      spare_q     <= '{default: '0};
      ip_q        <= '0;
      step_q      <= '0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      addr_q      <= addr_d;
      spare_q     <= spare_d;
      ip_q        <= ip_d;
      step_q      <= step_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgProgLen:  prog_len_q  <= cfg_wdata_i[PtrW-1:0];
          CfgMaxSteps: max_steps_q <= cfg_wdata_i[StepW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= func_i;
      lit_q   <= literal_i;
      paddr_q <= preload_address_i;
      pval_q  <= preload_value_i;
    end
    if (out_load) begin
      out_acc_q  <= acc_q;
      out_ptr_q  <= ip_q;
      out_halt_q <= halted_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accumulator_o  = out_acc_q;
  assign next_pointer_o = out_ptr_q;
  assign halted_o       = out_halt_q;

endmodule

FILE: rtl/bavm_checker.sv
// ----------------------------------------------------------------------------
// bavm_checker
// port-level checks of the byte accumulator machine core
// ----------------------------------------------------------------------------
module bavm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bavm_pkg::DataW-1:0]    accumulator_o,
  input logic [bavm_pkg::PtrW-1:0]     next_pointer_o,
  input logic                          halted_o
);

  // core stays busy through the exec state and the state after it once a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("core took a beat too early");

  // a result needs an accepted beat: no output beat appears right after idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !(in_valid_i) |=> !$rose(out_valid_o))
    else $error("output beat without input beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(accumulator_o) && $stable(next_pointer_o) && $stable(halted_o))
    else $error("stalled output payload changed");

endmodule

bind byte_accumulator_vm_core bavm_checker u_bavm_checker (.*);
